### hdl/i2c_master_bit_engine_top_assert.svh
// assertion macros for the i2c master bit engine
// each checks on the rising edge of clk and is idle while rst is high
`ifndef I2C_MASTER_BIT_ENGINE_TOP_ASSERT_SVH
`define I2C_MASTER_BIT_ENGINE_TOP_ASSERT_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("i2c bit engine check failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("i2c bit engine check failed");

`endif

### hdl/i2cm_pkg.sv
package i2cm_pkg;

  // operation codes of an input item
  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_WAIT  = 3'd4;
  localparam logic [2:0] OP_READ  = 3'd5;

  // engine modes, aligned with the operation codes
  localparam logic [2:0] MODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_START = 3'd1;
  localparam logic [2:0] MODE_STOP  = 3'd2;
  localparam logic [2:0] MODE_WRITE = 3'd3;
  localparam logic [2:0] MODE_WAIT  = 3'd4;
  localparam logic [2:0] MODE_READ  = 3'd5;

  localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;
  localparam int         Q_DEPTH           = 2;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_sample;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_enable;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_failed;
  } out_item_t;

  // queue status seen by the front end
  typedef struct packed {
    logic full;
    logic valid;
  } q_status_t;

endpackage

### hdl/i2c_master_bit_engine_top.sv
// i2c master bit engine
// in channel: one transfer per half-bit tick, carrying an optional command
//   (start, stop, write byte, wait ack, read byte) and the sampled sda level;
//   in_valid/in_stall, accepted when valid is high and stall is low
// out channel: one result per tick with scl/sda drive levels, sda enable,
//   busy, done, last received byte and ack failure flag; out_valid/out_stall
// cfg channel: cfg_valid/cfg_ready write of ack_timeout_ticks, always ready;
//   write only while no tick is in flight
// latency: a tick's result appears 2 cycles after acceptance when nothing
//   stalls (input register to queue slot, then engine plus output register)
// throughput: one tick per cycle; the engine state update is a single-cycle
//   loop and sets that figure
// a stall on the out side holds the result; the two-entry queue keeps taking
//   ticks until it fills, then in_stall rises
// reset: engine idle, scl and sda driven high, timeout back to 250, all
//   channels empty
module i2c_master_bit_engine_top import i2cm_pkg::*; #(
  parameter int QUEUE_DEPTH = Q_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  `include "i2c_master_bit_engine_top_assert.svh"

  logic       ack_timeout;
  logic [7:0] ack_timeout_ticks;
  q_status_t  q_status;
  logic       push;
  logic       pop;
  in_item_t   push_data;
  in_item_t   head;

  assign cfg_ready   = 1'b1;
  assign ack_timeout = cfg_valid && cfg_ready;

  // timeout register
  always_ff @(posedge clk) begin
    if (rst) begin
      ack_timeout_ticks <= ACK_TIMEOUT_RESET;
    end else if (ack_timeout) begin
      ack_timeout_ticks <= cfg_data;
    end
  end

  i2cm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  i2cm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .status    (q_status),
    .head      (head)
  );

  i2cm_back u_back (
    .clk         (clk),
    .rst         (rst),
    .ack_timeout (ack_timeout_ticks),
    .q_status    (q_status),
    .cmd         (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

  // a released data line always reads as high
  `ASSERT_IMPL(a_release_high, out_valid && !out_data.sda_enable, out_data.sda_level)
  // a completed command never reports busy
  `ASSERT_IMPL(a_done_not_busy, out_valid && out_data.done_res, !out_data.busy_res)
  // a timeout write lands in the register
  `ASSERT_NEXT(a_cfg_write, ack_timeout, ack_timeout_ticks == $past(cfg_data))

endmodule

### hdl/i2cm_front.sv
module i2cm_front import i2cm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  input  q_status_t q_status,
  output logic      push,
  output in_item_t  push_data
);

  logic     f_valid;
  in_item_t f_item;
  in_item_t dec_item;

  // classify: unknown codes become a plain tick
  always_comb begin
    dec_item = in_data;
    unique case (in_data.operation)
      OP_START, OP_STOP, OP_WRITE, OP_WAIT, OP_READ: dec_item.operation = in_data.operation;
      default: dec_item.operation = OP_TICK;
    endcase
  end

  assign in_stall  = f_valid && q_status.full;
  assign push      = f_valid && !q_status.full;
  assign push_data = f_item;

  // input stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (!in_stall) begin
      f_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      f_item <= dec_item;
    end
  end

endmodule

### hdl/i2cm_queue.sv
module i2cm_queue import i2cm_pkg::*; #(
  parameter int DEPTH = Q_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  in_item_t  push_data,
  input  logic      pop,
  output q_status_t status,
  output in_item_t  head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST  = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULLC = CW'(DEPTH);

  in_item_t      slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign status.full  = (count == FULLC);
  assign status.valid = (count != '0);
  assign head         = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

### hdl/i2cm_back.sv
module i2cm_back import i2cm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] ack_timeout,
  input  q_status_t  q_status,
  input  in_item_t   cmd,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data
);

  logic [2:0] mode, mode_e, mode_n;
  logic [4:0] phase, phase_e, phase_n;
  logic [7:0] shift, shift_e, shift_n;
  logic [7:0] wait_cnt, wait_n;
  logic       scl, scl_n;
  logic       sda, sda_n;
  logic       dir, dir_n;
  logic       fail, fail_n;
  logic       ack_choice, ack_e;
  logic [7:0] rx_hold, rx_n;
  logic       done;

  assign pop = q_status.valid && (!out_valid || !out_stall);

  // command launch while idle
  always_comb begin
    mode_e  = mode;
    phase_e = phase;
    shift_e = shift;
    ack_e   = ack_choice;
    if (mode == MODE_IDLE && cmd.operation != OP_TICK) begin
      mode_e  = cmd.operation;
      phase_e = '0;
      if (cmd.operation == OP_WRITE) begin
        shift_e = cmd.tx_byte;
      end
      if (cmd.operation == OP_READ) begin
        shift_e = '0;
        ack_e   = cmd.send_ack;
      end
    end
  end

  // one phase of the running command
  always_comb begin
    mode_n  = mode_e;
    phase_n = phase_e;
    shift_n = shift_e;
    wait_n  = wait_cnt;
    scl_n   = scl;
    sda_n   = sda;
    dir_n   = dir;
    fail_n  = fail;
    rx_n    = rx_hold;
    done    = 1'b0;
    unique case (mode_e)
      MODE_START: begin
        if (phase_e == 5'd0) begin
          dir_n = 1'b1;
          sda_n = 1'b1;
          scl_n = 1'b1;
        end else if (phase_e == 5'd1) begin
          sda_n = 1'b0;
        end else begin
          scl_n = 1'b0;
          done  = 1'b1;
        end
        phase_n = phase_e + 5'd1;
      end
      MODE_STOP: begin
        if (phase_e == 5'd0) begin
          dir_n = 1'b1;
          scl_n = 1'b0;
          sda_n = 1'b0;
        end else if (phase_e == 5'd1) begin
          scl_n = 1'b1;
        end else begin
          sda_n = 1'b1;
          done  = 1'b1;
        end
        phase_n = phase_e + 5'd1;
      end
      MODE_WRITE: begin
        if (!phase_e[4]) begin
          if (!phase_e[0]) begin
            scl_n   = 1'b0;
            dir_n   = 1'b1;
            sda_n   = shift_e[7];
            shift_n = {shift_e[6:0], 1'b0};
          end else begin
            scl_n = 1'b1;
          end
        end else begin
          scl_n = 1'b0;
          done  = 1'b1;
        end
        phase_n = phase_e + 5'd1;
      end
      MODE_WAIT: begin
        priority if (phase_e == 5'd0) begin
          dir_n   = 1'b0;
          sda_n   = 1'b1;
          scl_n   = 1'b0;
          wait_n  = '0;
          phase_n = 5'd1;
        end else if (phase_e == 5'd1) begin
          scl_n   = 1'b1;
          phase_n = 5'd2;
        end else if (!cmd.sda_sample) begin
          scl_n  = 1'b0;
          fail_n = 1'b0;
          done   = 1'b1;
        end else if (wait_cnt >= ack_timeout) begin
          // timeout: pull both lines low and finish with a stop
          fail_n  = 1'b1;
          dir_n   = 1'b1;
          scl_n   = 1'b0;
          sda_n   = 1'b0;
          mode_n  = MODE_STOP;
          phase_n = 5'd1;
        end else begin
          wait_n = wait_cnt + 8'd1;
        end
      end
      MODE_READ: begin
        if (!phase_e[4]) begin
          if (!phase_e[0]) begin
            scl_n = 1'b0;
            dir_n = 1'b0;
            sda_n = 1'b1;
          end else begin
            scl_n   = 1'b1;
            shift_n = {shift_e[6:0], cmd.sda_sample};
          end
        end else if (phase_e == 5'd16) begin
          scl_n = 1'b0;
          dir_n = 1'b1;
          sda_n = !ack_e;
        end else if (phase_e == 5'd17) begin
          scl_n = 1'b1;
        end else begin
          scl_n = 1'b0;
          rx_n  = shift_e;
          done  = 1'b1;
        end
        phase_n = phase_e + 5'd1;
      end
      default: begin
        mode_n = MODE_IDLE;
      end
    endcase
    if (done) begin
      mode_n  = MODE_IDLE;
      phase_n = '0;
    end
  end

  // engine state, advanced once per transfer taken from the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      phase      <= '0;
      shift      <= '0;
      wait_cnt   <= '0;
      scl        <= 1'b1;
      sda        <= 1'b1;
      dir        <= 1'b1;
      fail       <= 1'b0;
      ack_choice <= 1'b0;
      rx_hold    <= '0;
    end else if (pop) begin
      mode       <= mode_n;
      phase      <= phase_n;
      shift      <= shift_n;
      wait_cnt   <= wait_n;
      scl        <= scl_n;
      sda        <= sda_n;
      dir        <= dir_n;
      fail       <= fail_n;
      ack_choice <= ack_e;
      rx_hold    <= rx_n;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data.scl_level  <= scl_n;
      out_data.sda_level  <= sda_n;
      out_data.sda_enable <= dir_n;
      out_data.busy_res   <= (mode_n != MODE_IDLE);
      out_data.done_res   <= done;
      out_data.rx_byte    <= rx_n;
      out_data.ack_failed <= fail_n;
    end
  end

endmodule

### tb/sv/i2c_bit_engine_check_pkg.sv
package i2c_bit_engine_check_pkg;
  import i2cm_pkg::*;

  // tracks the bus levels the engine should drive, tick by tick
  class bus_level_tracker;
    logic [2:0] mode;
    logic [4:0] phase;
    logic [7:0] shifter;
    logic [7:0] wait_cnt;
    logic [7:0] timeout;
    logic [7:0] rx_last;
    logic       scl;
    logic       sda;
    logic       sda_oe;
    logic       failed;
    logic       ack_sel;
    out_item_t  levels_due[$];
    int         errors;
    int         ticks;
    int         results;
    int         timeouts;
    int         reads_done;
    int         started[8];

    function new();
      mode = MODE_IDLE;
      phase = '0;
      shifter = '0;
      wait_cnt = '0;
      timeout = ACK_TIMEOUT_RESET;
      rx_last = '0;
      scl = 1'b1;
      sda = 1'b1;
      sda_oe = 1'b1;
      failed = 1'b0;
      ack_sel = 1'b0;
      errors = 0;
      ticks = 0;
      results = 0;
      timeouts = 0;
      reads_done = 0;
      foreach (started[i]) started[i] = 0;
    endfunction

    function void set_timeout(logic [7:0] value);
      timeout = value;
    endfunction

    // advance the engine copy by one accepted tick and queue its levels
    function void take_tick(in_item_t t);
      out_item_t  want;
      logic       fin;
      logic [4:0] p;
      fin = 1'b0;
      ticks++;
      // a new command only starts from idle
      if (mode == MODE_IDLE && t.operation >= OP_START && t.operation <= OP_READ) begin
        mode = t.operation;
        phase = '0;
        started[t.operation]++;
        if (t.operation == OP_WRITE) shifter = t.tx_byte;
        if (t.operation == OP_READ) begin
          shifter = '0;
          ack_sel = t.send_ack;
        end
      end
      p = phase;
      case (mode)
        MODE_START: begin
          if (p == 0) begin
            sda_oe = 1'b1;
            sda = 1'b1;
            scl = 1'b1;
          end else if (p == 1) begin
            sda = 1'b0;
          end else begin
            scl = 1'b0;
            fin = 1'b1;
          end
          phase = 5'(p + 1);
        end
        MODE_STOP: begin
          if (p == 0) begin
            sda_oe = 1'b1;
            scl = 1'b0;
            sda = 1'b0;
          end else if (p == 1) begin
            scl = 1'b1;
          end else begin
            sda = 1'b1;
            fin = 1'b1;
          end
          phase = 5'(p + 1);
        end
        MODE_WRITE: begin
          // data moves while scl is low, msb first
          if (p < 16) begin
            if (!p[0]) begin
              scl = 1'b0;
              sda_oe = 1'b1;
              sda = shifter[7];
              shifter = {shifter[6:0], 1'b0};
            end else begin
              scl = 1'b1;
            end
          end else begin
            scl = 1'b0;
            fin = 1'b1;
          end
          phase = 5'(p + 1);
        end
        MODE_WAIT: begin
          if (p == 0) begin
            sda_oe = 1'b0;
            sda = 1'b1;
            scl = 1'b0;
            wait_cnt = '0;
            phase = 5'd1;
          end else if (p == 1) begin
            scl = 1'b1;
            phase = 5'd2;
          end else if (!t.sda_sample) begin
            scl = 1'b0;
            failed = 1'b0;
            fin = 1'b1;
          end else if (wait_cnt >= timeout) begin
            // give up and finish with the rest of a stop
            failed = 1'b1;
            timeouts++;
            sda_oe = 1'b1;
            scl = 1'b0;
            sda = 1'b0;
            mode = MODE_STOP;
            phase = 5'd1;
          end else begin
            wait_cnt = wait_cnt + 8'd1;
          end
        end
        MODE_READ: begin
          if (p < 16) begin
            if (!p[0]) begin
              scl = 1'b0;
              sda_oe = 1'b0;
              sda = 1'b1;
            end else begin
              scl = 1'b1;
              shifter = {shifter[6:0], t.sda_sample};
            end
          end else if (p == 16) begin
            scl = 1'b0;
            sda_oe = 1'b1;
            sda = !ack_sel;
          end else if (p == 17) begin
            scl = 1'b1;
          end else begin
            scl = 1'b0;
            rx_last = shifter;
            fin = 1'b1;
            reads_done++;
          end
          phase = 5'(p + 1);
        end
        default: mode = MODE_IDLE;
      endcase
      if (fin) begin
        mode = MODE_IDLE;
        phase = '0;
      end
      want.scl_level = scl;
      want.sda_level = sda;
      want.sda_enable = sda_oe;
      want.busy_res = (mode != MODE_IDLE);
      want.done_res = fin;
      want.rx_byte = rx_last;
      want.ack_failed = failed;
      levels_due.push_back(want);
    endfunction

    function string show(out_item_t x);
      return $sformatf("scl=%b sda=%b oe=%b busy=%b done=%b rx=%h fail=%b",
                       x.scl_level, x.sda_level, x.sda_enable, x.busy_res,
                       x.done_res, x.rx_byte, x.ack_failed);
    endfunction

    // compare one result transfer with the oldest expected levels
    function void match_levels(out_item_t got);
      out_item_t want;
      string     bad;
      results++;
      if (levels_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result %0d arrived with none expected: %s", results, show(got));
        return;
      end
      want = levels_due.pop_front();
      bad = "";
      if (got.scl_level !== want.scl_level) bad = {bad, " scl_level"};
      if (got.sda_level !== want.sda_level) bad = {bad, " sda_level"};
      if (got.sda_enable !== want.sda_enable) bad = {bad, " sda_enable"};
      if (got.busy_res !== want.busy_res) bad = {bad, " busy_res"};
      if (got.done_res !== want.done_res) bad = {bad, " done_res"};
      if (got.rx_byte !== want.rx_byte) bad = {bad, " rx_byte"};
      if (got.ack_failed !== want.ack_failed) bad = {bad, " ack_failed"};
      if (bad != "") begin
        errors++;
        if (errors <= 10) begin
          $display("result %0d mismatch in%s", results, bad);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

endpackage

### tb/sv/i2c_master_bit_engine_top_test.sv
module i2c_master_bit_engine_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import i2cm_pkg::*;
  import i2c_bit_engine_check_pkg::*;

  localparam int LIMIT = 600000;
  localparam int PHASE_TICKS = 100;
  // operation codes with no command behind them
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  // one planned command: the item, high samples for an ack wait, forced read level
  typedef struct {
    in_item_t item;
    int       highs;
    int       fill;
  } bus_cmd_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = '0;

  int       send_pct = 18;
  int       recv_pct = 72;
  int       cycles = 0;
  int       settings = 0;
  int       highs_left = 0;
  int       fill_level = -1;
  bus_cmd_t plan[$];

  bus_level_tracker trk = new();

  i2c_master_bit_engine_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver stalls at random
  always @(posedge clk) begin
    out_stall <= rst ? 1'b0 : ($urandom_range(0, 99) < recv_pct);
  end

  // check every result transfer
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) trk.match_levels(out_data);
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic void add(logic [2:0] op, logic [7:0] data, logic ack, int highs, int fill);
    bus_cmd_t c;
    c.item.operation = op;
    c.item.tx_byte = data;
    c.item.send_ack = ack;
    c.item.sda_sample = 1'($urandom);
    c.highs = highs;
    c.fill = fill;
    plan.push_back(c);
  endfunction

  // how many high samples an ack wait sees; some reach or pass the timeout
  function automatic int pick_highs();
    int r;
    int t;
    r = $urandom_range(0, 99);
    t = int'(trk.timeout);
    if (r < 75) return int'($urandom_range(0, 3));
    if (r < 92) return (t == 0) ? int'($urandom_range(0, 1)) : t - 1 + int'($urandom_range(0, 2));
    return t + 1 + int'($urandom_range(0, 2));
  endfunction

  // queue one random bus transaction, mostly well formed
  function automatic void plan_transaction();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 78) begin
      add(OP_START, 8'($urandom), 1'($urandom), 0, -1);
      add(OP_WRITE, 8'($urandom), 1'($urandom), 0, -1);
      add(OP_WAIT, 8'($urandom), 1'($urandom), -1, -1);
      n = $urandom_range(0, 3);
      repeat (n) begin
        if ($urandom_range(0, 1)) begin
          add(OP_WRITE, 8'($urandom), 1'($urandom), 0, -1);
          add(OP_WAIT, 8'($urandom), 1'($urandom), -1, -1);
        end else begin
          add(OP_READ, 8'($urandom), 1'($urandom), 0, -1);
        end
      end
      // now and then a repeated start instead of a stop
      if ($urandom_range(0, 9) != 0) add(OP_STOP, 8'($urandom), 1'($urandom), 0, -1);
    end else if (r < 90) begin
      add(3'($urandom), 8'($urandom), 1'($urandom), -1, -1);
    end else if (r < 96) begin
      repeat ($urandom_range(1, 4)) add(OP_TICK, 8'($urandom), 1'($urandom), 0, -1);
    end else begin
      add(OP_READ, 8'($urandom), 1'($urandom), 0, -1);
      add(OP_WAIT, 8'($urandom), 1'($urandom), -1, -1);
      add(OP_STOP, 8'($urandom), 1'($urandom), 0, -1);
    end
  endfunction

  // next tick: filler while a command runs, else the next planned command
  function automatic in_item_t next_tick();
    in_item_t t;
    bus_cmd_t c;
    t.operation = OP_TICK;
    t.tx_byte = 8'($urandom);
    t.send_ack = 1'($urandom);
    t.sda_sample = 1'($urandom);
    if (trk.mode != MODE_IDLE) begin
      // commands issued while busy must be ignored
      if ($urandom_range(0, 3) == 0) t.operation = 3'($urandom);
      if (trk.mode == MODE_WAIT && trk.phase >= 2) begin
        t.sda_sample = (highs_left > 0);
        if (highs_left > 0) highs_left--;
      end else if (fill_level >= 0) begin
        t.sda_sample = fill_level[0];
      end
    end else begin
      if (plan.size() == 0) plan_transaction();
      c = plan.pop_front();
      t = c.item;
      highs_left = (c.highs < 0) ? pick_highs() : c.highs;
      fill_level = c.fill;
    end
    return t;
  endfunction

  // send ticks; count 0 runs the plan out, either way stop with the engine idle
  task automatic send_ticks(input int count);
    int taken;
    bit loaded;
    taken = 0;
    loaded = 1'b0;
    while (loaded || trk.mode != MODE_IDLE ||
           ((count > 0) ? (taken < count) : (plan.size() != 0))) begin
      if (!loaded) begin
        if ($urandom_range(0, 99) < send_pct) begin
          in_valid <= 1'b0;
        end else begin
          in_data <= next_tick();
          in_valid <= 1'b1;
          loaded = 1'b1;
        end
      end
      @(posedge clk);
      if (in_valid && !in_stall) begin
        trk.take_tick(in_data);
        loaded = 1'b0;
        taken++;
      end
    end
    in_valid <= 1'b0;
  endtask

  // hold off until every expected result has come
  task automatic drain();
    while (trk.levels_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [7:0] value);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    trk.set_timeout(value);
    settings++;
  endtask

  initial begin
    int         ph;
    logic [7:0] limits [6];
    limits[0] = 8'd255;
    limits[1] = 8'd3;
    limits[2] = 8'd0;
    limits[3] = 8'($urandom_range(2, 16));
    limits[4] = 8'd1;
    limits[5] = ACK_TIMEOUT_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: spare codes, all-ones and all-zeros bytes, ack and nack reads
    add(OP_SPARE_LO, 8'h00, 1'b0, 0, -1);
    add(OP_SPARE_HI, 8'hFF, 1'b1, 0, -1);
    add(OP_TICK, 8'h00, 1'b0, 0, -1);
    add(OP_START, 8'h00, 1'b0, 0, -1);
    add(OP_WRITE, 8'hFF, 1'b0, 0, -1);
    add(OP_WAIT, 8'h00, 1'b0, 0, -1);
    add(OP_WRITE, 8'h00, 1'b1, 0, -1);
    add(OP_WAIT, 8'h00, 1'b0, 4, -1);
    add(OP_READ, 8'h00, 1'b1, 0, 1);
    add(OP_READ, 8'hFF, 1'b0, 0, 0);
    add(OP_STOP, 8'h00, 1'b0, 0, -1);
    add(OP_STOP, 8'h00, 1'b0, 0, -1);
    add(OP_START, 8'h00, 1'b0, 0, -1);
    add(OP_START, 8'h00, 1'b0, 0, -1);
    add(OP_STOP, 8'h00, 1'b0, 0, -1);
    send_ticks(0);

    // zero timeout: the first high sample fails, a stop keeps the flag,
    // a later good ack clears it
    drain();
    write_timeout(8'd0);
    add(OP_START, 8'h00, 1'b0, 0, -1);
    add(OP_WRITE, 8'hA5, 1'b0, 0, -1);
    add(OP_WAIT, 8'h00, 1'b0, 1, -1);
    add(OP_STOP, 8'h00, 1'b0, 0, -1);
    add(OP_WAIT, 8'h00, 1'b0, 0, -1);
    add(OP_STOP, 8'h00, 1'b0, 0, -1);
    send_ticks(0);

    // random traffic over several timeout settings and idling patterns
    for (ph = 0; ph < 6; ph++) begin
      send_pct = (ph < 2) ? 18 : (ph < 4) ? 72 : 0;
      recv_pct = (ph < 2) ? 72 : (ph < 4) ? 18 : 0;
      drain();
      write_timeout(limits[ph]);
      if (ph == 1) begin
        send_ticks(PHASE_TICKS / 2);
        drain();
        send_ticks(PHASE_TICKS / 2);
      end else begin
        send_ticks(PHASE_TICKS);
      end
    end

    drain();
    repeat (10) @(posedge clk);
    $display("ran %0d ticks, checked %0d results over %0d timeout settings, %0d mismatches",
             trk.ticks, trk.results, settings, trk.errors);
    $display("commands: start %0d stop %0d write %0d ack wait %0d (%0d timed out) read %0d",
             trk.started[OP_START], trk.started[OP_STOP], trk.started[OP_WRITE],
             trk.started[OP_WAIT], trk.timeouts, trk.started[OP_READ]);
    if (trk.errors == 0 && trk.levels_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
